// File: hw/rtl/dlle_pkg.sv
// Package for the doubly linked list engine.
// Holds opcodes, status codes and the fixed field widths shared by the interface and top-level files.
// No dependencies.
package dlle_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [OP_W-1:0] OP_ADD_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE_AT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: hw/rtl/dlle_if.sv
// Valid/ready channel interfaces for the doubly linked list engine.
// Depends on dlle_pkg for field widths.
interface dlle_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [dlle_pkg::OP_W-1:0]           opcode;
    logic signed [dlle_pkg::VALUE_W-1:0] value;
    logic [dlle_pkg::POS_W-1:0]          position;

    modport source (output valid, output opcode, output value, output position,
                    input ready);
    modport sink   (input valid, input opcode, input value, input position,
                    output ready);
endinterface

interface dlle_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [dlle_pkg::STATUS_W-1:0]       status;
    logic signed [dlle_pkg::VALUE_W-1:0] data;
    logic [dlle_pkg::LEN_W-1:0]          length;

    modport source (output valid, output status, output data, output length,
                    input ready);
    modport sink   (input valid, input status, input data, input length,
                    output ready);
endinterface

// File: hw/rtl/dlle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/doubly_linked_list_engine_top.sv
// Top level of the doubly linked list engine: sequencer around two RAMs.
// Depends on dlle_pkg, dlle_if.sv (channel interfaces) and dlle_ram.
//
//  Channel | Dir | Payload                     | Transfer
//  --------+-----+-----------------------------+---------------------------
//  cmd     | in  | opcode, value, position     | cmd.valid && cmd.ready
//  rsp     | out | status, data, length        | rsp.valid && rsp.ready
//
//  One command at a time. Add: decode, then a link fix-up of the old head or
//  tail if any. Read/delete at position P: the walk reads one link per cycle
//  from the link RAM, then a delete repairs the links of its neighbours.
//  A finished result sits in the output register; the next command is taken
//  while it waits. rst_n clears control state at once; RAM contents are only
//  reached through live links, so they need no clearing.
module doubly_linked_list_engine_top #(
    parameter int POOL_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    dlle_cmd_if.sink   cmd,
    dlle_rsp_if.source rsp
);

    // Entry index with one extra code for null.
    localparam int AW   = $clog2(POOL_DEPTH);
    localparam int IW   = $clog2(POOL_DEPTH + 1);
    localparam int LW   = 2 * IW;
    localparam int CMPW = (IW > dlle_pkg::POS_W) ? IW : dlle_pkg::POS_W;
    localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_FIXP   = 3'd3;
    localparam logic [2:0] S_FIXN   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] state_reg, state_next;

    // latched command
    logic [dlle_pkg::OP_W-1:0]           op_reg;
    logic signed [dlle_pkg::VALUE_W-1:0] value_reg;
    logic [dlle_pkg::POS_W-1:0]          pos_reg;

    // list bookkeeping
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [IW-1:0]         count_reg, count_next;
    logic [POOL_DEPTH-1:0] free_reg, free_next;

    // walk and link repair
    logic [IW-1:0]              cur_reg, cur_next;
    logic [dlle_pkg::POS_W-1:0] steps_reg, steps_next;
    logic [IW-1:0]              p_reg, p_next;
    logic [IW-1:0]              n_reg, n_next;

    // result being built
    logic [dlle_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic signed [dlle_pkg::VALUE_W-1:0] res_data_reg, res_data_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [dlle_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic signed [dlle_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic [dlle_pkg::LEN_W-1:0]          out_length_reg, out_length_next;

    // RAM ports
    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [LW-1:0]         link_rdata;
    logic                  data_we;
    logic [AW-1:0]         data_waddr;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [DATA_WIDTH-1:0] data_rdata;
    logic signed [DATA_WIDTH-1:0] data_rdata_s;
    logic [AW-1:0]         rd_addr;

    // link word: {next, prev}
    logic [IW-1:0] rd_next;
    logic [IW-1:0] rd_prev;

    // lowest free entry: isolate lowest set bit, then encode
    logic [POOL_DEPTH-1:0] free_low;
    logic [IW-1:0]         alloc_idx;
    logic                  pool_full;
    logic                  pos_ok;
    logic                  out_free;

    assign rd_next      = link_rdata[LW-1:IW];
    assign rd_prev      = link_rdata[IW-1:0];
    assign data_rdata_s = data_rdata;
    assign free_low     = free_reg & (~free_reg + POOL_DEPTH'(1));
    assign pool_full    = (free_reg == '0);
    assign pos_ok       = (pos_reg != '0) && (CMPW'(pos_reg) <= CMPW'(count_reg));
    assign out_free     = !out_valid_reg || rsp.ready;

    always_comb
    begin
        alloc_idx = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            alloc_idx = alloc_idx | (free_low[i] ? IW'(i) : '0);
        end
    end

    dlle_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    dlle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (rd_addr),
        .rdata (data_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        status_next     = status_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_length_next = out_length_reg;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        data_we    = 1'b0;
        data_waddr = alloc_idx[AW-1:0];
        data_wdata = DATA_WIDTH'(value_reg);
        rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next   = dlle_pkg::ST_OK;
                res_data_next = '0;
                state_next    = S_RESP;
                unique case (op_reg) inside
                    dlle_pkg::OP_ADD_HEAD, dlle_pkg::OP_ADD_TAIL:
                    begin
                        if (pool_full)
                        begin
                            status_next = dlle_pkg::ST_FULL;
                        end
                        else
                        begin
                            data_we    = 1'b1;
                            link_we    = 1'b1;
                            link_waddr = alloc_idx[AW-1:0];
                            free_next[alloc_idx[AW-1:0]] = 1'b0;
                            count_next = count_reg + IW'(1);
                            if (op_reg == dlle_pkg::OP_ADD_HEAD)
                            begin
                                link_wdata = {head_reg, NIL};
                                head_next  = alloc_idx;
                                p_next     = alloc_idx;
                                n_next     = head_reg;
                                if (head_reg == NIL)
                                begin
                                    tail_next = alloc_idx;
                                end
                                else
                                begin
                                    rd_addr    = head_reg[AW-1:0];
                                    state_next = S_FIXN;
                                end
                            end
                            else
                            begin
                                link_wdata = {NIL, tail_reg};
                                tail_next  = alloc_idx;
                                p_next     = tail_reg;
                                n_next     = alloc_idx;
                                if (tail_reg == NIL)
                                begin
                                    head_next = alloc_idx;
                                end
                                else
                                begin
                                    rd_addr    = tail_reg[AW-1:0];
                                    state_next = S_FIXP;
                                end
                            end
                        end
                    end
                    dlle_pkg::OP_DELETE_AT, dlle_pkg::OP_READ_AT:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = dlle_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            steps_next = pos_reg - dlle_pkg::POS_W'(1);
                            rd_addr    = head_reg[AW-1:0];
                            state_next = S_WALK;
                        end
                    end
                    dlle_pkg::OP_DELETE_ALL:
                    begin
                        free_next  = '1;
                        head_next  = NIL;
                        tail_next  = NIL;
                        count_next = '0;
                    end
                    default:
                    begin
                        // unused opcodes: no change, status ok
                    end
                endcase
            end

            S_WALK:
            begin
                // RAM output holds the words of entry cur_reg
                if (steps_reg != '0)
                begin
                    cur_next   = rd_next;
                    steps_next = steps_reg - dlle_pkg::POS_W'(1);
                    rd_addr    = rd_next[AW-1:0];
                end
                else if (op_reg == dlle_pkg::OP_READ_AT)
                begin
                    res_data_next = dlle_pkg::VALUE_W'(data_rdata_s);
                    state_next    = S_RESP;
                end
                else
                begin
                    free_next[cur_reg[AW-1:0]] = 1'b1;
                    count_next = count_reg - IW'(1);
                    p_next     = rd_prev;
                    n_next     = rd_next;
                    if (rd_prev == NIL)
                    begin
                        head_next = rd_next;
                    end
                    if (rd_next == NIL)
                    begin
                        tail_next = rd_prev;
                    end
                    if (rd_prev != NIL)
                    begin
                        rd_addr    = rd_prev[AW-1:0];
                        state_next = S_FIXP;
                    end
                    else if (rd_next != NIL)
                    begin
                        rd_addr    = rd_next[AW-1:0];
                        state_next = S_FIXN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_FIXP:
            begin
                // next of p becomes n, keep its prev
                link_we    = 1'b1;
                link_waddr = p_reg[AW-1:0];
                link_wdata = {n_reg, rd_prev};
                if (op_reg == dlle_pkg::OP_DELETE_AT && n_reg != NIL)
                begin
                    rd_addr    = n_reg[AW-1:0];
                    state_next = S_FIXN;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_FIXN:
            begin
                // prev of n becomes p, keep its next
                link_we    = 1'b1;
                link_waddr = n_reg[AW-1:0];
                link_wdata = {rd_next, p_reg};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = res_data_reg;
                    out_length_next = dlle_pkg::LEN_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            count_reg     <= '0;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= cmd.opcode;
            value_reg <= cmd.value;
            pos_reg   <= cmd.position;
        end
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        p_reg          <= p_next;
        n_reg          <= n_next;
        status_reg     <= status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_length_reg <= out_length_next;
    end

    assign cmd.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.length = out_length_reg;

endmodule
